// ===== src/srbd_pkg.sv =====
package srbd_pkg;

  // Channel values: 0..65535 stands for 0.0..1.0.
  localparam int unsigned CH_W = 16;
  localparam int unsigned NCH  = 4;

  localparam logic [CH_W-1:0] ONE_Q16  = 16'hFFFF;
  localparam logic [8:0]      HARD_ONE = 9'd256;

  // Coverage division: 64-bit numerator, 48-bit divisor, 16 quotient bits.
  localparam int unsigned NUM_W = 64;
  localparam int unsigned DEN_W = 48;
  localparam int unsigned QUO_W = 16;

  // Register stages: five in front of the divider, one per quotient bit,
  // four for coverage select and blend.
  localparam int unsigned PIPE_LATENCY = 5 + QUO_W + 4;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 4'd0,
    CFG_CENTER_Y    = 4'd1,
    CFG_RADIUS      = 4'd2,
    CFG_HARDNESS    = 4'd3,
    CFG_PAINT_RED   = 4'd4,
    CFG_PAINT_GREEN = 4'd5,
    CFG_PAINT_BLUE  = 4'd6,
    CFG_PAINT_ALPHA = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [CH_W-1:0]    dst_red;
    logic [CH_W-1:0]    dst_green;
    logic [CH_W-1:0]    dst_blue;
    logic [CH_W-1:0]    dst_alpha;
  } srbd_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic [CH_W-1:0] coverage;
  } srbd_out_t;

  // Index 0 red, 1 green, 2 blue, 3 alpha.
  typedef logic [NCH-1:0][CH_W-1:0] chan_t;

  // Travels alongside the division.
  typedef struct packed {
    logic  in_disc;
    logic  hard;
    chan_t dst;
  } srbd_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    srbd_side_t       side;
  } div_req_t;

endpackage

// ===== src/srbd_div.sv =====
module srbd_div import srbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  div_req_t         in_req_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [QUO_W-1:0] out_quo_o,
  output srbd_side_t       out_side_o
);

  // Restoring division, one quotient bit per stage, MSB first.
  // The quotient must fit in QUO_W bits.
  logic             v_q    [QUO_W];
  logic [NUM_W-1:0] rem_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  srbd_side_t       side_q [QUO_W];
  logic             rdy    [QUO_W+1];

  assign rdy[QUO_W] = out_ready_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    srbd_side_t       side_in;
    logic [NUM_W-1:0] dsh;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = in_req_i.num;
      assign quo_in  = '0;
      assign side_in = in_req_i.side;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh    = {{(NUM_W-DEN_W){1'b0}}, den_i} << (QUO_W - 1 - k);
    assign take   = rem_in >= dsh;
    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k]  <= take ? rem_in - dsh : rem_in;
        quo_q[k]  <= quo_in | ({{(QUO_W-1){1'b0}}, take} << (QUO_W - 1 - k));
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QUO_W-1];
  assign out_quo_o   = quo_q[QUO_W-1];
  assign out_side_o  = side_q[QUO_W-1];

endmodule

// ===== src/soft_round_brush_dab.sv =====
// Soft round brush dab: blends one dab of paint into a stream of pixels, one
// pixel per clock. Each beat on the input carries integer pixel coordinates
// and the pixel's current RGBA; each beat on the output carries the blended
// RGBA and the coverage used. Inside radius*hardness the coverage equals
// paint_alpha, between that inner radius and the outer radius it falls
// linearly in squared distance to zero, and at or beyond the radius it is
// zero. Every channel, alpha included, becomes old*(1-cov) + paint*cov,
// rounded to nearest. The 16-stage coverage divider (one quotient bit per
// stage) makes up most of the pipeline, and a new pixel enters every cycle
// while in_stall_o is low. The pipeline holds up to 25 pixels; stages
// with a bubble keep filling while the output is stalled, so in_stall_o
// rises only when every stage is occupied and the output beat is held.
// The configuration port is always ready; write registers only while no
// pixel is in flight.
module soft_round_brush_dab import srbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  srbd_in_t              in_data_i,
  // pixel output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output srbd_out_t             out_data_o,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [23:0] center_x_q;
  logic signed [23:0] center_y_q;
  logic [15:0]        radius_q;
  logic [8:0]         hardness_q;
  logic [CH_W-1:0]    paint_red_q;
  logic [CH_W-1:0]    paint_green_q;
  logic [CH_W-1:0]    paint_blue_q;
  logic [CH_W-1:0]    paint_alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      radius_q      <= '0;
      hardness_q    <= HARD_ONE;
      paint_red_q   <= '0;
      paint_green_q <= '0;
      paint_blue_q  <= '0;
      paint_alpha_q <= ONE_Q16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTER_X:    center_x_q    <= cfg_data_i;
        CFG_CENTER_Y:    center_y_q    <= cfg_data_i;
        CFG_RADIUS:      radius_q      <= cfg_data_i[15:0];
        CFG_HARDNESS:    hardness_q    <= cfg_data_i[8:0];
        CFG_PAINT_RED:   paint_red_q   <= cfg_data_i[15:0];
        CFG_PAINT_GREEN: paint_green_q <= cfg_data_i[15:0];
        CFG_PAINT_BLUE:  paint_blue_q  <= cfg_data_i[15:0];
        CFG_PAINT_ALPHA: paint_alpha_q <= cfg_data_i[15:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Dab constants, recomputed every cycle from the registers. After a write
  // they settle (r2_q, ri_q, ri2_q, den_q) before any pixel stage reads them.
  //   r2  = radius^2            (Q.16)
  //   ri2 = (radius*hardness)^2 (Q.32)
  //   den = r2<<16 - ri2        (soft-zone divisor)
  // ---------------------------------------------------------------------
  logic [8:0]       hard_sat_w;
  logic [24:0]      ri_full_w;
  logic [31:0]      r2_q;
  logic [23:0]      ri_q;
  logic [47:0]      ri2_q;
  logic [DEN_W-1:0] den_q;

  // hardness above one saturates to one
  assign hard_sat_w = (hardness_q > HARD_ONE) ? HARD_ONE : hardness_q;
  assign ri_full_w  = radius_q * hard_sat_w;

  always_ff @(posedge clk_i) begin
    r2_q  <= radius_q * radius_q;
    ri_q  <= ri_full_w[23:0];
    ri2_q <= ri_q * ri_q;
    den_q <= {r2_q, 16'd0} - ri2_q;
  end

  chan_t paint_w;
  chan_t dst_in_w;

  assign paint_w  = {paint_alpha_q, paint_blue_q, paint_green_q, paint_red_q};
  assign dst_in_w = {in_data_i.dst_alpha, in_data_i.dst_blue,
                     in_data_i.dst_green, in_data_i.dst_red};

  // ---------------------------------------------------------------------
  // Handshake: each stage loads when it is empty or the stage after it
  // moves on. The chain runs from the output register back to the input.
  // ---------------------------------------------------------------------
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_div;
  logic rdy_k, rdy_m, rdy_s, rdy_o;
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic k_v_q, m_v_q, s_v_q, o_v_q;

  assign rdy_o = !o_v_q || !out_stall_i;
  assign rdy_s = !s_v_q || rdy_o;
  assign rdy_m = !m_v_q || rdy_s;
  assign rdy_k = !k_v_q || rdy_m;
  assign rdy_e = !e_v_q || rdy_div;
  assign rdy_d = !d_v_q || rdy_e;
  assign rdy_c = !c_v_q || rdy_d;
  assign rdy_b = !b_v_q || rdy_c;
  assign rdy_a = !a_v_q || rdy_b;

  assign in_stall_o = !rdy_a;

  // ---------------------------------------------------------------------
  // Stage A: offsets from the dab center in Q.8
  // ---------------------------------------------------------------------
  logic signed [24:0] px_w, py_w, cx_w, cy_w;
  logic signed [24:0] a_dx_q, a_dy_q;
  chan_t              a_dst_q;

  assign px_w = {in_data_i.pixel_x[15], in_data_i.pixel_x, 8'd0};
  assign py_w = {in_data_i.pixel_y[15], in_data_i.pixel_y, 8'd0};
  assign cx_w = {center_x_q[23], center_x_q};
  assign cy_w = {center_y_q[23], center_y_q};

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_dx_q  <= px_w - cx_w;
      a_dy_q  <= py_w - cy_w;
      a_dst_q <= dst_in_w;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: squares (each below 2^48)
  // ---------------------------------------------------------------------
  logic signed [49:0] dx2_w, dy2_w;
  logic [47:0]        b_dx2_q, b_dy2_q;
  chan_t              b_dst_q;

  assign dx2_w = a_dx_q * a_dx_q;
  assign dy2_w = a_dy_q * a_dy_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_v_q) begin
      b_dx2_q <= dx2_w[47:0];
      b_dy2_q <= dy2_w[47:0];
      b_dst_q <= a_dst_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: squared distance, Q.16
  // ---------------------------------------------------------------------
  logic [48:0] c_d2_q;
  chan_t       c_dst_q;

  always_ff @(posedge clk_i) begin
    if (rdy_c && b_v_q) begin
      c_d2_q  <= {1'b0, b_dx2_q} + {1'b0, b_dy2_q};
      c_dst_q <= b_dst_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: zone tests. The hard test and the difference only matter
  // inside the radius, where d2 fits in 32 bits.
  // ---------------------------------------------------------------------
  logic        d_inside_q, d_hard_q;
  logic [31:0] d_diff_q;
  chan_t       d_dst_q;

  always_ff @(posedge clk_i) begin
    if (rdy_d && c_v_q) begin
      d_inside_q <= c_d2_q < {17'd0, r2_q};
      d_hard_q   <= {c_d2_q[31:0], 16'd0} < ri2_q;
      d_diff_q   <= r2_q - c_d2_q[31:0];
      d_dst_q    <= c_dst_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage E: soft-zone numerator (r2 - d2) * paint_alpha
  // ---------------------------------------------------------------------
  logic        e_inside_q, e_hard_q;
  logic [47:0] e_num_q;
  chan_t       e_dst_q;

  always_ff @(posedge clk_i) begin
    if (rdy_e && d_v_q) begin
      e_num_q    <= d_diff_q * paint_alpha_q;
      e_inside_q <= d_inside_q;
      e_hard_q   <= d_hard_q;
      e_dst_q    <= d_dst_q;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: ((r2 - d2)<<16 * paint_alpha) / (r2<<16 - ri2). In the soft
  // zone the quotient never exceeds paint_alpha, so 16 bits suffice.
  // ---------------------------------------------------------------------
  div_req_t         div_req_w;
  logic             div_v_w;
  logic [QUO_W-1:0] div_quo_w;
  srbd_side_t       div_side_w;

  assign div_req_w.num          = {e_num_q, 16'd0};
  assign div_req_w.side.in_disc = e_inside_q;
  assign div_req_w.side.hard    = e_hard_q;
  assign div_req_w.side.dst     = e_dst_q;

  srbd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (e_v_q),
    .in_ready_o  (rdy_div),
    .in_req_i    (div_req_w),
    .den_i       (den_q),
    .out_valid_o (div_v_w),
    .out_ready_i (rdy_k),
    .out_quo_o   (div_quo_w),
    .out_side_o  (div_side_w)
  );

  // ---------------------------------------------------------------------
  // Stage K: pick the coverage for the pixel's zone
  // ---------------------------------------------------------------------
  logic [CH_W-1:0] k_cov_q;
  chan_t           k_dst_q;

  always_ff @(posedge clk_i) begin
    if (rdy_k && div_v_w) begin
      if (!div_side_w.in_disc) begin
        k_cov_q <= '0;
      end else if (div_side_w.hard) begin
        k_cov_q <= paint_alpha_q;
      end else begin
        k_cov_q <= div_quo_w;
      end
      k_dst_q <= div_side_w.dst;
    end
  end

  // ---------------------------------------------------------------------
  // Stage M: blend products per channel
  // ---------------------------------------------------------------------
  logic [CH_W-1:0]        inv_w;
  logic [NCH-1:0][31:0]   m_p1_q, m_p2_q;
  logic [CH_W-1:0]        m_cov_q;

  assign inv_w = ONE_Q16 - k_cov_q;

  always_ff @(posedge clk_i) begin
    if (rdy_m && k_v_q) begin
      for (int c = 0; c < NCH; c++) begin
        m_p1_q[c] <= k_dst_q[c] * inv_w;
        m_p2_q[c] <= paint_w[c] * k_cov_q;
      end
      m_cov_q <= k_cov_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage S: sum plus half for rounding (fits 32 bits since the weights
  // add up to 65535)
  // ---------------------------------------------------------------------
  logic [NCH-1:0][31:0] s_sum_q;
  logic [CH_W-1:0]      s_cov_q;

  always_ff @(posedge clk_i) begin
    if (rdy_s && m_v_q) begin
      for (int c = 0; c < NCH; c++) begin
        s_sum_q[c] <= m_p1_q[c] + m_p2_q[c] + 32'd32767;
      end
      s_cov_q <= m_cov_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage O: divide by 65535 and clamp. x = q0*65535 + (q0 + lo) with
  // q0 = x>>16; the remainder stays below 2*65535, so one correction.
  // ---------------------------------------------------------------------
  function automatic logic [CH_W-1:0] div_by_one(input logic [31:0] s);
    logic [16:0] q0;
    logic [16:0] r;
    logic [16:0] q;
    q0 = {1'b0, s[31:16]};
    r  = {1'b0, s[15:0]} + q0;
    q  = q0 + ((r >= {1'b0, ONE_Q16}) ? 17'd1 : 17'd0);
    return (q > {1'b0, ONE_Q16}) ? ONE_Q16 : q[15:0];
  endfunction

  srbd_out_t o_data_q;

  always_ff @(posedge clk_i) begin
    if (rdy_o && s_v_q) begin
      o_data_q.out_red   <= div_by_one(s_sum_q[0]);
      o_data_q.out_green <= div_by_one(s_sum_q[1]);
      o_data_q.out_blue  <= div_by_one(s_sum_q[2]);
      o_data_q.out_alpha <= div_by_one(s_sum_q[3]);
      o_data_q.coverage  <= s_cov_q;
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits, advanced with their stages
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      k_v_q <= 1'b0;
      m_v_q <= 1'b0;
      s_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (rdy_a) a_v_q <= in_valid_i;
      if (rdy_b) b_v_q <= a_v_q;
      if (rdy_c) c_v_q <= b_v_q;
      if (rdy_d) d_v_q <= c_v_q;
      if (rdy_e) e_v_q <= d_v_q;
      if (rdy_k) k_v_q <= div_v_w;
      if (rdy_m) m_v_q <= k_v_q;
      if (rdy_s) s_v_q <= m_v_q;
      if (rdy_o) o_v_q <= s_v_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_data_q;

endmodule

// ===== src/srbd_chk.sv =====
module srbd_chk import srbd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input srbd_out_t out_data_o
);

  // A held output beat stays.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A held output beat does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // With the output register empty the whole pipeline can move.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // An accepted pixel, or one ahead of it, shows at the output after the
  // pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##PIPE_LATENCY out_valid_o)
    else $error("output missing after pipeline latency");

endmodule

bind soft_round_brush_dab srbd_chk u_srbd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/soft_round_brush_dab_test.sv =====
`timescale 1ns / 100ps

module soft_round_brush_dab_test;
  import srbd_pkg::*;

  typedef longint unsigned u64_t;

  localparam int NUM_REGS    = CFG_PAINT_ALPHA + 1;
  localparam int SEG_PIXELS  = 115;   // pixels per random dab setting
  localparam int SEGMENTS    = 4;     // dab settings per idling phase
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off, well past pipeline depth
  localparam int PRESS_PIXELS = 80;   // pixels offered during the hold-off
  localparam int TIMEOUT_NS  = 400_000;

  // Dab register copy plus the queue of blended pixels still owed by the block.
  class dab_scoreboard;
    logic signed [23:0] center_x, center_y;
    logic [15:0]        radius;
    logic [8:0]         hardness;
    logic [15:0]        paint_r, paint_g, paint_b, paint_a;
    srbd_out_t          blended_q[$];
    int                 mismatches;

    function new();
      center_x   = '0;
      center_y   = '0;
      radius     = '0;
      hardness   = HARD_ONE;
      paint_r    = '0;
      paint_g    = '0;
      paint_b    = '0;
      paint_a    = ONE_Q16;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER_X:    center_x = data;
        CFG_CENTER_Y:    center_y = data;
        CFG_RADIUS:      radius   = data[15:0];
        CFG_HARDNESS:    hardness = data[8:0];
        CFG_PAINT_RED:   paint_r  = data[15:0];
        CFG_PAINT_GREEN: paint_g  = data[15:0];
        CFG_PAINT_BLUE:  paint_b  = data[15:0];
        CFG_PAINT_ALPHA: paint_a  = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] mix(u64_t old, u64_t paint, u64_t cov);
      u64_t v;
      v = (old * (u64_t'(ONE_Q16) - cov) + paint * cov + 32767) / u64_t'(ONE_Q16);
      return (v > u64_t'(ONE_Q16)) ? ONE_Q16 : v[15:0];
    endfunction

    // Coverage from squared distance, then the four channel blends.
    function srbd_out_t paint_pixel(srbd_in_t p);
      longint     dx, dy;
      u64_t       d2, r2, ri, ri2, d2w, r2w, cov;
      logic [8:0] h;
      srbd_out_t  o;
      dx  = longint'($signed(p.pixel_x)) * 256 - longint'(center_x);
      dy  = longint'($signed(p.pixel_y)) * 256 - longint'(center_y);
      d2  = u64_t'(dx * dx) + u64_t'(dy * dy);
      r2  = u64_t'(radius) * u64_t'(radius);
      h   = (hardness > HARD_ONE) ? HARD_ONE : hardness;
      ri  = u64_t'(radius) * u64_t'(h);
      ri2 = ri * ri;
      cov = 0;
      if (d2 < r2) begin
        d2w = d2 << 16;
        r2w = r2 << 16;
        if (d2w < ri2) cov = paint_a;
        else cov = ((r2w - d2w) * u64_t'(paint_a)) / (r2w - ri2);
      end
      if (cov > u64_t'(ONE_Q16)) cov = ONE_Q16;
      o.out_red   = mix(p.dst_red,   paint_r, cov);
      o.out_green = mix(p.dst_green, paint_g, cov);
      o.out_blue  = mix(p.dst_blue,  paint_b, cov);
      o.out_alpha = mix(p.dst_alpha, paint_a, cov);
      o.coverage  = cov[15:0];
      return o;
    endfunction

    function void note_pixel(srbd_in_t p);
      blended_q.push_back(paint_pixel(p));
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(srbd_out_t got);
      srbd_out_t want;
      if (blended_q.size() == 0) begin
        $error("output beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      want = blended_q.pop_front();
      check_field("out_red",   want.out_red,   got.out_red);
      check_field("out_green", want.out_green, got.out_green);
      check_field("out_blue",  want.out_blue,  got.out_blue);
      check_field("out_alpha", want.out_alpha, got.out_alpha);
      check_field("coverage",  want.coverage,  got.coverage);
    endfunction

    function int pending();
      return blended_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  srbd_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  srbd_out_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  dab_scoreboard board = new();

  // Idling knobs, in percent per cycle; written by the stimulus process only.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Hold-off handshake: stimulus bumps the request count, receiver the done count.
  int hold_requests = 0;
  int holds_done    = 0;

  soft_round_brush_dab u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the handshakes lock up.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: check each accepted beat against the oldest expectation (values
  // sampled right after the edge are the ones the edge saw), then pick the
  // stall for the next cycle. A pending hold-off request overrides the random
  // stall and is counted down here, in cycles.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_beat(out_data_o);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one pixel, with random idle cycles in front of it; return once the
  // beat is taken. Valid stays high into the next pixel when no gap follows.
  task automatic send_pixel(input srbd_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel(p);
  endtask

  // Drop valid, wait until every owed pixel is out, then let the pipeline empty.
  task automatic finish_burst();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // One register beat; valid is left high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  // Load a full dab setting. Unused upper data bits carry junk, and one write
  // goes to an index past the register file, which must be ignored.
  task automatic load_dab(input int cx, input int cy, input int rad, input int hard,
                          input int red, input int green, input int blue,
                          input int alpha);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_IDX_W-1:0]  spare_idx;
    junk      = CFG_DATA_W'($urandom());
    spare_idx = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, NUM_REGS));
    write_reg(CFG_CENTER_X,    cx[23:0]);
    write_reg(CFG_CENTER_Y,    cy[23:0]);
    write_reg(CFG_RADIUS,      {junk[23:16], rad[15:0]});
    write_reg(spare_idx,       junk);
    write_reg(CFG_HARDNESS,    {junk[23:9], hard[8:0]});
    write_reg(CFG_PAINT_RED,   {junk[23:16], red[15:0]});
    write_reg(CFG_PAINT_GREEN, {junk[23:16], green[15:0]});
    write_reg(CFG_PAINT_BLUE,  {junk[23:16], blue[15:0]});
    write_reg(CFG_PAINT_ALPHA, {junk[23:16], alpha[15:0]});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random dab, weighted toward small radii so most pixels land near the edge
  // zone, with the extremes of radius, hardness and opacity mixed in.
  task automatic random_dab();
    int cx, cy, rad, hard, alpha;
    if ($urandom_range(4) == 0) begin
      cx = $urandom();
      cy = $urandom();
    end else begin
      cx = $urandom_range(25600) - 12800;
      cy = $urandom_range(25600) - 12800;
    end
    case ($urandom_range(9))
      0:       rad = 0;
      1:       rad = 65535;
      2:       rad = $urandom_range(65535);
      default: rad = $urandom_range(12 * 256, 1);
    endcase
    case ($urandom_range(5))
      0:       hard = 0;
      1:       hard = HARD_ONE;
      2:       hard = $urandom_range(511, HARD_ONE + 1);
      default: hard = $urandom_range(HARD_ONE - 1, 1);
    endcase
    case ($urandom_range(5))
      0:       alpha = 0;
      1:       alpha = ONE_Q16;
      default: alpha = $urandom_range(65535);
    endcase
    load_dab(cx, cy, rad, hard, $urandom_range(65535), $urandom_range(65535),
             $urandom_range(65535), alpha);
  endtask

  function automatic srbd_in_t make_px(int x, int y, int red, int green, int blue,
                                       int alpha);
    srbd_in_t p;
    p.pixel_x   = x[15:0];
    p.pixel_y   = y[15:0];
    p.dst_red   = red[15:0];
    p.dst_green = green[15:0];
    p.dst_blue  = blue[15:0];
    p.dst_alpha = alpha[15:0];
    return p;
  endfunction

  // Mostly pixels within a couple of pixels of the dab, the rest anywhere.
  function automatic srbd_in_t random_pixel();
    srbd_in_t p;
    int       span, x, y;
    p = {$urandom(), $urandom(), $urandom()};
    if ($urandom_range(9) < 7) begin
      span = int'(board.radius >> 8) + 2;
      x = (int'(board.center_x) >>> 8) + int'($urandom_range(2 * span)) - span;
      y = (int'(board.center_y) >>> 8) + int'($urandom_range(2 * span)) - span;
      p.pixel_x = x[15:0];
      p.pixel_y = y[15:0];
    end
    return p;
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting has zero radius: every pixel passes through uncovered.
    send_pixel(make_px(-32768, -32768, 0, 0, 0, 0));
    send_pixel(make_px(32767, 32767, 65535, 65535, 65535, 65535));
    send_pixel(make_px(0, 0, 'h1234, 'h8000, 'hFFFF, 'h0001));
    finish_burst();

    // Centre at the corners of its range, largest radius, hardness above one.
    load_dab('h7FFFFF, -8388608, 65535, 511, 65535, 65535, 65535, 65535);
    send_pixel(make_px(32767, -32768, 0, 0, 0, 0));
    send_pixel(make_px(-32768, 32767, 65535, 65535, 65535, 65535));
    send_pixel(make_px(32760, -32760, 'h5555, 'hAAAA, 'h0F0F, 'hF0F0));
    finish_burst();

    // Full hardness: covered strictly inside, nothing on the radius itself.
    load_dab(0, 0, 10 * 256, HARD_ONE, 'h1234, 'hABCD, 0, 50000);
    send_pixel(make_px(10, 0, 'h8000, 'h8000, 'h8000, 'h8000));
    send_pixel(make_px(9, 0, 'h8000, 'h8000, 'h8000, 'h8000));
    send_pixel(make_px(0, -10, 0, 65535, 0, 65535));
    send_pixel(make_px(7, 7, 65535, 0, 65535, 0));
    finish_burst();

    // Half hardness with a half-pixel centre: walk across the soft zone.
    load_dab(128, 128, 8 * 256, 128, 65535, 0, 'h8000, 40000);
    send_pixel(make_px(0, 0, 0, 65535, 0, 0));
    send_pixel(make_px(2, 2, 0, 65535, 0, 0));
    send_pixel(make_px(4, 0, 'h4000, 'hC000, 'h1111, 'h2222));
    send_pixel(make_px(5, 5, 'h4000, 'hC000, 'h1111, 'h2222));
    send_pixel(make_px(8, 0, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF));
    send_pixel(make_px(-7, 1, 65535, 65535, 65535, 65535));
    finish_burst();

    // Zero hardness: the whole disc is soft.
    load_dab(0, 0, 4 * 256, 0, 0, 65535, 'h7FFF, 65535);
    send_pixel(make_px(0, 0, 'h3333, 'h3333, 'h3333, 'h3333));
    send_pixel(make_px(1, 1, 'h3333, 'h3333, 'h3333, 'h3333));
    send_pixel(make_px(3, 2, 65535, 0, 65535, 0));
    finish_burst();

    // Transparent paint: coverage is zero even inside, pixel passes unchanged.
    load_dab(0, 0, 4 * 256, 200, 65535, 65535, 65535, 0);
    send_pixel(make_px(1, 0, 'h0123, 'h4567, 'h89AB, 'hCDEF));
    finish_burst();

    // Random part: four idling phases, each with several dab settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 49; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        random_dab();
        for (int n = 0; n < SEG_PIXELS; n++) send_pixel(random_pixel());
        if (ph == 0 && seg == 1) begin
          // Hold the output off long enough to fill every stage and push
          // back on the input, while pixels keep coming.
          hold_requests++;
          for (int n = 0; n < PRESS_PIXELS; n++) send_pixel(random_pixel());
          finish_burst();
          // Resume on the same dab after the pipeline has fully drained.
          for (int n = 0; n < SEG_PIXELS / 4; n++) send_pixel(random_pixel());
        end
        finish_burst();
      end
    end

    stall_pct = 0;
    if (board.pending() != 0) begin
      $error("%0d expected pixels never came out", board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
